// ----- sv/wsfd_pkg.sv -----
// ----------------------------------------------------------------------------
// wsfd_pkg - shared types and codes for the WebSocket frame deframer
// Parse phases, status and action codes, and the request payload structs.
// ----------------------------------------------------------------------------
package wsfd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_DISCARD = 3'd5
  } phase_t;

  typedef enum logic [3:0] {
    ST_OK           = 4'd0,
    ST_INCOMPLETE   = 4'd1,
    ST_FRAGMENTED   = 4'd2,
    ST_EXTENSION    = 4'd3,
    ST_UNMASKED     = 4'd4,
    ST_CONTINUATION = 4'd5,
    ST_LEN64        = 4'd6,
    ST_BINARY       = 4'd7,
    ST_CLOSE        = 4'd8,
    ST_PINGPONG     = 4'd9,
    ST_OTHER        = 4'd10
  } status_t;

  typedef enum logic [1:0] {
    ACT_KEEP       = 2'd0,
    ACT_CLOSE      = 2'd1,
    ACT_SEND_CLOSE = 2'd2
  } action_t;

  // Frame opcodes
  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  // Length codes in the second header byte
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       chunk_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       is_payload;
    logic       message_end;
    status_t    status;
    action_t    action;
  } result_t;

endpackage

// ----- sv/wsfd_if.sv -----
// ----------------------------------------------------------------------------
// wsfd_if - valid/ready channels of the WebSocket frame deframer
// One interface for received bytes, one for deframed results.
// ----------------------------------------------------------------------------
interface wsfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       chunk_end;

  modport source (output valid, output data_byte, output chunk_end, input ready);
  modport sink   (input valid, input data_byte, input chunk_end, output ready);
endinterface

interface wsfd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       is_payload;
  logic       message_end;
  logic [3:0] status;
  logic [1:0] action;

  modport source (output valid, output payload_byte, output is_payload,
                  output message_end, output status, output action, input ready);
  modport sink   (input valid, input payload_byte, input is_payload,
                  input message_end, input status, input action, output ready);
endinterface

// ----- sv/wsfd_in_reg.sv -----
// ----------------------------------------------------------------------------
// wsfd_in_reg - input register of the deframer
// Captures one received byte per cycle and holds it while the result side stalls.
// ----------------------------------------------------------------------------
module wsfd_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  wsfd_pkg::in_item_t in_item,
  input  logic              advance,
  output logic              item_valid,
  output wsfd_pkg::in_item_t item
);

  logic               valid_r;
  logic               valid_nxt;
  wsfd_pkg::in_item_t item_r;

  // Take a new request when the slot is empty or is being consumed
  assign in_ready  = !valid_r || advance;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ----- sv/wsfd_parser.sv -----
// ----------------------------------------------------------------------------
// wsfd_parser - frame header parser and payload unmasker
// Holds the frame state and judges one byte per step.
// ----------------------------------------------------------------------------
module wsfd_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  wsfd_pkg::in_item_t item,
  output logic               res_valid,
  output wsfd_pkg::result_t  res
);

  wsfd_pkg::phase_t  phase_r, phase_nxt;
  logic [3:0]        opcode_r, opcode_nxt;
  logic [15:0]       len_r, len_nxt;
  logic [3:0][7:0]   mask_r, mask_nxt;
  logic [1:0]        hcnt_r, hcnt_nxt;
  logic [15:0]       pcnt_r, pcnt_nxt;

  logic [7:0]        b;
  logic              last;
  logic [6:0]        code;
  logic [15:0]       pcnt_inc;
  logic              pay_done;
  logic [7:0]        plain;

  assign b        = item.data_byte;
  assign last     = item.chunk_end;
  assign code     = b[6:0];
  assign pcnt_inc = pcnt_r + 16'd1;
  assign pay_done = (pcnt_inc == len_r);
  assign plain    = b ^ mask_r[pcnt_r[1:0]];

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      wsfd_pkg::PH_HDR0: begin
        if (last) begin
          phase_nxt = wsfd_pkg::PH_HDR0;
        end else if (!b[7] || (b[6:4] != 3'd0)) begin
          phase_nxt = wsfd_pkg::PH_DISCARD;
        end else begin
          phase_nxt = wsfd_pkg::PH_HDR1;
        end
      end
      wsfd_pkg::PH_HDR1: begin
        if (b[7] && (opcode_r == wsfd_pkg::OP_TEXT) && (code != wsfd_pkg::LEN_EXT64)) begin
          if (last) begin
            phase_nxt = wsfd_pkg::PH_HDR0;
          end else if (code == wsfd_pkg::LEN_EXT16) begin
            phase_nxt = wsfd_pkg::PH_EXTLEN;
          end else begin
            phase_nxt = wsfd_pkg::PH_MASK;
          end
        end else begin
          phase_nxt = last ? wsfd_pkg::PH_HDR0 : wsfd_pkg::PH_DISCARD;
        end
      end
      wsfd_pkg::PH_EXTLEN: begin
        if (last) begin
          phase_nxt = wsfd_pkg::PH_HDR0;
        end else if (hcnt_r != 2'd0) begin
          phase_nxt = wsfd_pkg::PH_MASK;
        end
      end
      wsfd_pkg::PH_MASK: begin
        if (hcnt_r == 2'd3) begin
          if (len_r == 16'd0) begin
            phase_nxt = last ? wsfd_pkg::PH_HDR0 : wsfd_pkg::PH_DISCARD;
          end else begin
            phase_nxt = last ? wsfd_pkg::PH_HDR0 : wsfd_pkg::PH_PAYLOAD;
          end
        end else if (last) begin
          phase_nxt = wsfd_pkg::PH_HDR0;
        end
      end
      wsfd_pkg::PH_PAYLOAD: begin
        if (pay_done) begin
          phase_nxt = last ? wsfd_pkg::PH_HDR0 : wsfd_pkg::PH_DISCARD;
        end else if (last) begin
          phase_nxt = wsfd_pkg::PH_HDR0;
        end
      end
      default: begin
        phase_nxt = last ? wsfd_pkg::PH_HDR0 : wsfd_pkg::PH_DISCARD;
      end
    endcase
  end

  // Frame fields and result
  always_comb begin
    opcode_nxt = opcode_r;
    len_nxt    = len_r;
    mask_nxt   = mask_r;
    hcnt_nxt   = hcnt_r;
    pcnt_nxt   = pcnt_r;
    res_valid  = 1'b0;
    res        = '{payload_byte: 8'd0, is_payload: 1'b0, message_end: 1'b0,
                   status: wsfd_pkg::ST_OK, action: wsfd_pkg::ACT_KEEP};
    unique case (phase_r)
      wsfd_pkg::PH_HDR0: begin
        opcode_nxt = 4'd0;
        len_nxt    = 16'd0;
        mask_nxt   = '0;
        hcnt_nxt   = 2'd0;
        pcnt_nxt   = 16'd0;
        if (last) begin
          res_valid  = 1'b1;
          res.status = wsfd_pkg::ST_INCOMPLETE;
        end else if (!b[7]) begin
          res_valid  = 1'b1;
          res.status = wsfd_pkg::ST_FRAGMENTED;
        end else if (b[6:4] != 3'd0) begin
          res_valid  = 1'b1;
          res.status = wsfd_pkg::ST_EXTENSION;
          res.action = wsfd_pkg::ACT_CLOSE;
        end else begin
          opcode_nxt = b[3:0];
        end
      end
      wsfd_pkg::PH_HDR1: begin
        res_valid = 1'b1;
        if (!b[7]) begin
          res.status = wsfd_pkg::ST_UNMASKED;
          res.action = wsfd_pkg::ACT_CLOSE;
        end else begin
          unique case (opcode_r) inside
            wsfd_pkg::OP_CONT: begin
              res.status = wsfd_pkg::ST_CONTINUATION;
              res.action = wsfd_pkg::ACT_CLOSE;
            end
            wsfd_pkg::OP_TEXT: begin
              if (code == wsfd_pkg::LEN_EXT64) begin
                res.status = wsfd_pkg::ST_LEN64;
              end else begin
                hcnt_nxt   = 2'd0;
                res_valid  = last;
                res.status = wsfd_pkg::ST_INCOMPLETE;
                if (code != wsfd_pkg::LEN_EXT16) begin
                  len_nxt = {9'd0, code};
                end
              end
            end
            wsfd_pkg::OP_BINARY: begin
              res.status = wsfd_pkg::ST_BINARY;
            end
            wsfd_pkg::OP_CLOSE: begin
              res.status = wsfd_pkg::ST_CLOSE;
              res.action = wsfd_pkg::ACT_SEND_CLOSE;
            end
            wsfd_pkg::OP_PING, wsfd_pkg::OP_PONG: begin
              res.status = wsfd_pkg::ST_PINGPONG;
            end
            default: begin
              res.status = wsfd_pkg::ST_OTHER;
            end
          endcase
        end
      end
      wsfd_pkg::PH_EXTLEN: begin
        len_nxt  = {len_r[7:0], b};
        hcnt_nxt = hcnt_r + 2'd1;
        if (last) begin
          res_valid  = 1'b1;
          res.status = wsfd_pkg::ST_INCOMPLETE;
        end else if (hcnt_r != 2'd0) begin
          hcnt_nxt = 2'd0;
        end
      end
      wsfd_pkg::PH_MASK: begin
        mask_nxt[hcnt_r] = b;
        if (hcnt_r == 2'd3) begin
          hcnt_nxt = 2'd0;
          pcnt_nxt = 16'd0;
          if (len_r == 16'd0) begin
            res_valid       = 1'b1;
            res.message_end = 1'b1;
          end else if (last) begin
            res_valid  = 1'b1;
            res.status = wsfd_pkg::ST_INCOMPLETE;
          end
        end else begin
          hcnt_nxt = hcnt_r + 2'd1;
          if (last) begin
            res_valid  = 1'b1;
            res.status = wsfd_pkg::ST_INCOMPLETE;
          end
        end
      end
      wsfd_pkg::PH_PAYLOAD: begin
        pcnt_nxt         = pcnt_inc;
        res_valid        = 1'b1;
        res.payload_byte = plain;
        res.is_payload   = 1'b1;
        if (pay_done) begin
          res.message_end = 1'b1;
        end else if (last) begin
          res.status = wsfd_pkg::ST_INCOMPLETE;
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= wsfd_pkg::PH_HDR0;
      opcode_r <= 4'd0;
      len_r    <= 16'd0;
      mask_r   <= '0;
      hcnt_r   <= 2'd0;
      pcnt_r   <= 16'd0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      opcode_r <= opcode_nxt;
      len_r    <= len_nxt;
      mask_r   <= mask_nxt;
      hcnt_r   <= hcnt_nxt;
      pcnt_r   <= pcnt_nxt;
    end
  end

endmodule

// ----- sv/wsfd_out_reg.sv -----
// ----------------------------------------------------------------------------
// wsfd_out_reg - result register of the deframer
// Holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module wsfd_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              res_valid,
  input  wsfd_pkg::result_t res,
  output logic              advance,
  output logic              out_valid,
  input  logic              out_ready,
  output wsfd_pkg::result_t out_res
);

  logic              valid_r;
  logic              valid_nxt;
  wsfd_pkg::result_t res_r;

  // Advance whenever the held result is gone or leaves this cycle
  assign advance   = !valid_r || out_ready;
  assign valid_nxt = advance ? (step && res_valid) : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ----- sv/websocket_frame_deframer_top.sv -----
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top - WebSocket client frame deframer
// Checks one frame per received chunk and unmasks its text payload.
// ----------------------------------------------------------------------------
// Usage:
//   in_stream  carries the received bytes, one request per byte, with
//              chunk_end high on the last byte of each chunk.
//   out_stream carries at most one result per byte: an unmasked text payload
//              byte, an empty-message marker, or a status with an action.
//   An accepted byte is held in the input register, parsed out of it, and
//   its result lands in the result register, where the receiver takes it.
//   Throughput: one byte per cycle while the receiver keeps taking results,
//   set by the single pass of header and unmask logic between the two
//   registers; bytes that give no result simply leave no entry in the result register.
//   Reset (rst_n low, synchronous) empties both registers and returns the
//   parser to the first header byte of a frame.
//   When the receiver stalls, the result register holds its request, the
//   input register holds the byte behind it and in_stream.ready drops only
//   once both are full; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_top (
  input  logic       clk,
  input  logic       rst_n,
  wsfd_in_if.sink    in_stream,
  wsfd_out_if.source out_stream
);

  wsfd_pkg::in_item_t in_item;
  wsfd_pkg::in_item_t item;
  wsfd_pkg::result_t  res;
  wsfd_pkg::result_t  out_res;
  logic               item_valid;
  logic               advance;
  logic               step;
  logic               res_valid;

  assign in_item.data_byte = in_stream.data_byte;
  assign in_item.chunk_end = in_stream.chunk_end;

  // Hold the incoming byte
  wsfd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_stream.valid),
    .in_ready   (in_stream.ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  // Parse only when the byte can move on into the result register
  assign step = item_valid && advance;

  wsfd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  wsfd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .res_valid (res_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_stream.valid),
    .out_ready (out_stream.ready),
    .out_res   (out_res)
  );

  assign out_stream.payload_byte = out_res.payload_byte;
  assign out_stream.is_payload   = out_res.is_payload;
  assign out_stream.message_end  = out_res.message_end;
  assign out_stream.status       = out_res.status;
  assign out_stream.action       = out_res.action;

endmodule
